// File: design/tspf_pkg.sv
// shared types and constants of the transport stream sync framer
`default_nettype none
package tspf_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFS_W   = 32;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  // register map, index = paddr[ADDR_W-1:2]
  localparam logic [ADDR_W-3:0] REG_SYNC_VALUE = '0;

  localparam logic [BYTE_W-1:0] SYNC_VALUE_RST = 8'd71;

  // taps of the lookahead line handed to the lock logic
  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] oldest;
    logic [BYTE_W-1:0] mid;
    logic [BYTE_W-1:0] newest;
  } tspf_taps_t;

endpackage
`default_nettype wire

// File: design/tspf_line.sv
// lookahead shift line with fill tracking and pending-evaluation flag
`default_nettype none
module tspf_line import tspf_pkg::*; #(
  parameter int unsigned PKT_LEN = 188
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [BYTE_W-1:0] in_byte,
  output logic                   in_ready,
  input  wire logic              adv,
  output tspf_taps_t             taps
);

  localparam int unsigned LINE_LEN = 2 * PKT_LEN + 1;
  localparam int unsigned FILL_W   = $clog2(LINE_LEN + 1);

  logic [BYTE_W-1:0] line_r [LINE_LEN];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic              pend_r;
  logic              pend_nxt;
  logic              acc;
  logic              full_after;

  assign in_ready   = !pend_r || adv;
  assign acc        = in_valid && in_ready;
  assign full_after = fill_r >= FILL_W'(LINE_LEN - 1);

  always_comb begin
    fill_nxt = fill_r;
    if (acc && (fill_r != FILL_W'(LINE_LEN))) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
    priority if (acc) begin
      pend_nxt = full_after;
    end else if (adv) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pend_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      pend_r <= pend_nxt;
    end
  end

  // newest byte enters at the top, oldest sits at index 0
  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < LINE_LEN - 1; i++) begin
        line_r[i] <= line_r[i+1];
      end
      line_r[LINE_LEN-1] <= in_byte;
    end
  end

  // fields in struct order: vld, oldest, mid, newest
  assign taps = {pend_r, line_r[0], line_r[PKT_LEN], line_r[LINE_LEN-1]};

endmodule
`default_nettype wire

// File: design/tspf_lock.sv
// sync lock tracking, packet framing and result register
`default_nettype none
module tspf_lock import tspf_pkg::*; #(
  parameter int unsigned PKT_LEN = 188
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tspf_taps_t        taps,
  input  wire logic [BYTE_W-1:0] sync_value,
  output logic                   adv,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_data_byte,
  output logic                   out_first_of_packet,
  output logic                   out_last_of_packet,
  output logic [OFFS_W-1:0]      out_packet_offset
);

  localparam int unsigned BIP_W = $clog2(PKT_LEN);

  logic              locked_r;
  logic [BIP_W-1:0]  bip_r;
  logic [OFFS_W-1:0] oldest_pos_r;
  logic [OFFS_W-1:0] pkt_start_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] data_r;
  logic              first_r;
  logic              last_r;
  logic [OFFS_W-1:0] offs_r;

  logic              at_start;
  logic              at_end;
  logic              keep;
  logic              hit;
  logic              lock_now;
  logic [OFFS_W-1:0] start_now;

  assign adv       = taps.vld && (!out_valid_r || out_ready);
  assign at_start  = bip_r == '0;
  assign at_end    = bip_r == BIP_W'(PKT_LEN - 1);
  // a wrong first byte at a packet boundary drops the lock
  assign keep      = locked_r && !(at_start && (taps.oldest != sync_value));
  assign hit       = (taps.oldest == sync_value) && (taps.mid == sync_value) &&
                     (taps.newest == sync_value);
  assign lock_now  = keep || hit;
  assign start_now = at_start ? oldest_pos_r : pkt_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r     <= 1'b0;
      bip_r        <= '0;
      oldest_pos_r <= '0;
      pkt_start_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (adv) begin
        locked_r     <= lock_now;
        oldest_pos_r <= oldest_pos_r + OFFS_W'(1);
        out_valid_r  <= lock_now;
        // byte index is zero whenever hunting, so a fresh lock starts at zero
        if (lock_now) begin
          pkt_start_r <= start_now;
          bip_r       <= at_end ? '0 : bip_r + BIP_W'(1);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r  <= taps.oldest;
      first_r <= at_start;
      last_r  <= at_end;
      offs_r  <= start_now;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data_byte       = data_r;
  assign out_first_of_packet = first_r;
  assign out_last_of_packet  = last_r;
  assign out_packet_offset   = offs_r;

endmodule
`default_nettype wire

// File: design/ts_packet_sync_framer_core.sv
// top level of the transport stream sync framer
//
// takes a transport stream one byte per transfer on the in_ channel and
// emits sync-aligned packets of PKT_LEN bytes on the out_ channel, each byte
// marked first/last and tagged with the stream offset of its packet's first
// byte (wraps at 2^32). a 2*PKT_LEN+1 byte shift line looks ahead: a byte
// leaves as a result only when it is the oldest in the line, so the first
// 2*PKT_LEN bytes after reset produce nothing. while hunting, bytes are
// dropped until the oldest byte, the one PKT_LEN later and the newest all
// match sync_value; a mismatching first byte at a packet boundary drops lock
// and is rechecked at once.
// throughput is one byte per cycle while out_ready stays high. the transfer
// completing a byte's lookahead window sets the line stage's pending flag,
// then the lock/framing stage registers the result. a stalled receiver holds
// the output register; at most one more byte is taken into the line stage,
// where it waits with in_ready low. reset clears the fill count, lock state
// and offsets and sets sync_value to 71; sync_value sits at apb address 0.
`default_nettype none
module ts_packet_sync_framer_core import tspf_pkg::*; #(
  parameter int unsigned PKT_LEN = 188
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_stream_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_data_byte,
  output logic                   out_first_of_packet,
  output logic                   out_last_of_packet,
  output logic [OFFS_W-1:0]      out_packet_offset
);

  logic [BYTE_W-1:0] sync_r;
  logic              sel_sync;
  tspf_taps_t        taps;
  logic              adv;

  assign pready   = 1'b1;
  assign sel_sync = paddr[ADDR_W-1:2] == REG_SYNC_VALUE;
  assign prdata   = sel_sync ? {{(DATA_W - BYTE_W){1'b0}}, sync_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_VALUE_RST;
    end else if (psel && penable && pwrite && sel_sync) begin
      sync_r <= pwdata[BYTE_W-1:0];
    end
  end

  tspf_line #(.PKT_LEN(PKT_LEN)) u_line (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_stream_byte),
    .in_ready (in_ready),
    .adv      (adv),
    .taps     (taps)
  );

  tspf_lock #(.PKT_LEN(PKT_LEN)) u_lock (
    .clk                 (clk),
    .rst_n               (rst_n),
    .taps                (taps),
    .sync_value          (sync_r),
    .adv                 (adv),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data_byte       (out_data_byte),
    .out_first_of_packet (out_first_of_packet),
    .out_last_of_packet  (out_last_of_packet),
    .out_packet_offset   (out_packet_offset)
  );

  // a ready receiver never backs up the input side
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // packets are at least two bytes, so the marks never coincide
  a_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_first_of_packet && out_last_of_packet))
    else $error("first and last mark on the same byte");

  // a pending evaluation only blocks input while the result side is stalled
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (taps.vld && !in_ready) |-> (out_valid && !out_ready))
    else $error("input stalled without a stalled result");

  // offset stays put while a stalled result waits
  a_hold_offs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_packet_offset))
    else $error("result offset changed during a stall");

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench of the transport stream sync framer, with a shadow framer model
`default_nettype none
module tb_top;
  import tspf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PKT_LEN  = 188;
  localparam int unsigned LINE_LEN = 2 * PKT_LEN + 1;
  // index with no register behind it
  localparam logic [ADDR_W-3:0] REG_UNUSED = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              is_first;
    logic              is_last;
    logic [OFFS_W-1:0] offs;
  } pkt_byte_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_stream_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_data_byte;
  logic              out_first_of_packet;
  logic              out_last_of_packet;
  logic [OFFS_W-1:0] out_packet_offset;

  ts_packet_sync_framer_core #(.PKT_LEN(PKT_LEN)) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_stream_byte      (in_stream_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data_byte       (out_data_byte),
    .out_first_of_packet (out_first_of_packet),
    .out_last_of_packet  (out_last_of_packet),
    .out_packet_offset   (out_packet_offset)
  );

  always #5 clk = ~clk;

  // shadow copy of the framer state
  logic [BYTE_W-1:0] line_sh [LINE_LEN];
  int unsigned       fill_sh;
  logic              locked_sh;
  int unsigned       bip_sh;
  logic [OFFS_W-1:0] oldest_pos_sh;
  logic [OFFS_W-1:0] pkt_start_sh;
  logic [BYTE_W-1:0] sync_sh;

  pkt_byte_t bytes_due [$];
  int        mismatch_cnt = 0;
  bit        idle_on = 1'b1;
  bit        long_hold_req = 1'b0;
  int        hold_left = 0;
  int        stall_left = 0;

  task automatic shadow_reset();
    foreach (line_sh[i]) line_sh[i] = '0;
    fill_sh       = 0;
    locked_sh     = 1'b0;
    bip_sh        = 0;
    oldest_pos_sh = '0;
    pkt_start_sh  = '0;
    sync_sh       = SYNC_VALUE_RST;
  endtask

  // one byte through the shadow framer, queueing the packet byte it releases
  task automatic frame_predict(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] oldest;
    pkt_byte_t         r;
    if (fill_sh >= LINE_LEN) fill_sh = LINE_LEN - 1;
    line_sh[fill_sh] = b;
    fill_sh++;
    if (fill_sh < LINE_LEN) return;
    oldest = line_sh[0];
    if (locked_sh && bip_sh == 0 && oldest != sync_sh) locked_sh = 1'b0;
    // lost lock is rechecked on the same byte
    if (!locked_sh && oldest == sync_sh && line_sh[PKT_LEN] == sync_sh &&
        line_sh[2*PKT_LEN] == sync_sh) begin
      locked_sh = 1'b1;
      bip_sh    = 0;
    end
    if (locked_sh) begin
      if (bip_sh == 0) pkt_start_sh = oldest_pos_sh;
      r.data     = oldest;
      r.is_first = (bip_sh == 0);
      r.is_last  = (bip_sh == PKT_LEN - 1);
      r.offs     = pkt_start_sh;
      bytes_due.push_back(r);
      bip_sh++;
      if (bip_sh >= PKT_LEN) bip_sh = 0;
    end
    for (int i = 0; i < LINE_LEN - 1; i++) line_sh[i] = line_sh[i+1];
    line_sh[LINE_LEN-1] = '0;
    fill_sh       = LINE_LEN - 1;
    oldest_pos_sh = oldest_pos_sh + 1;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    do @(posedge clk); while (!in_ready);
    frame_predict(b);
  endtask

  task automatic apb_xfer(input logic wr, input logic [ADDR_W-3:0] idx,
                          input logic [DATA_W-1:0] wdata,
                          output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (wr && idx == REG_SYNC_VALUE) sync_sh = wdata[BYTE_W-1:0];
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [ADDR_W-3:0] idx, input logic [DATA_W-1:0] wdata);
    logic [DATA_W-1:0] unused;
    apb_xfer(1'b1, idx, wdata, unused);
  endtask

  task automatic cfg_check_sync();
    logic [DATA_W-1:0] rd;
    apb_xfer(1'b0, REG_SYNC_VALUE, '0, rd);
    if (rd !== {{(DATA_W-BYTE_W){1'b0}}, sync_sh}) begin
      $display("%0t ns: sync_value readback mismatch, expected %0h actual %0h",
               $time, sync_sh, rd);
      mismatch_cnt++;
    end
  endtask

  // stop sending, let every due byte come out, then give the pipeline time to settle
  task automatic drain_idle();
    in_valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // random bytes, about a third of them equal to the current sync byte
  task automatic send_noise(input int n);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) send_byte(sync_sh);
      else send_byte(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // packets with the current sync byte; some get a bad sync byte or a slip before them
  task automatic send_packets(input int n_pkts, input int bad_pct, input int slip_pct,
                              input int hold_at);
    for (int p = 0; p < n_pkts; p++) begin
      if ($urandom_range(0, 99) < slip_pct)
        repeat ($urandom_range(1, 5)) send_byte(BYTE_W'($urandom_range(0, 255)));
      if (p == hold_at) long_hold_req = 1'b1;
      if ($urandom_range(0, 99) < bad_pct)
        send_byte(sync_sh ^ BYTE_W'($urandom_range(1, 255)));
      else
        send_byte(sync_sh);
      repeat (PKT_LEN - 1) send_byte(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_register_access();
    cfg_check_sync();
    cfg_write(REG_UNUSED, 32'h0000_0013);
    cfg_check_sync();
    // upper bits of the write data are dropped
    cfg_write(REG_SYNC_VALUE, 32'hABCD_EF47);
    cfg_check_sync();
  endtask

  task automatic test_fill_extremes();
    logic [BYTE_W-1:0] seq [16] = '{8'h00, 8'hFF, 8'h47, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'hAA,
                                    8'h55, 8'h47, 8'h47, 8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h47};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_lock_default_sync();
    repeat ($urandom_range(0, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
    // receiver makes one long hold, requested as the third packet starts, around the lock
    send_packets(3, 0, 0, 2);
  endtask

  // a new sync byte drops the lock at the next packet boundary
  task automatic test_lock_loss();
    drain_idle();
    cfg_write(REG_SYNC_VALUE, 32'h0000_0000);
    cfg_check_sync();
    send_noise(8);
  endtask

  task automatic test_sync_extremes();
    logic [BYTE_W-1:0] vals [2];
    vals[0] = 8'hFF;
    vals[1] = BYTE_W'($urandom_range(0, 255));
    foreach (vals[i]) begin
      drain_idle();
      cfg_write(REG_SYNC_VALUE, {24'($urandom_range(0, 16777215)), vals[i]});
      cfg_check_sync();
      send_noise(8);
    end
  endtask

  task automatic test_steady_final();
    drain_idle();
    cfg_write(REG_SYNC_VALUE, {{(DATA_W-BYTE_W){1'b0}}, SYNC_VALUE_RST});
    cfg_check_sync();
    idle_on = 1'b0;
    send_noise(12);
  endtask

  // result side: comparison against the oldest due byte
  always @(posedge clk) begin
    pkt_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (bytes_due.size() == 0) begin
        $display("%0t ns: transfer with nothing due, expected none actual %0h",
                 $time, out_data_byte);
        mismatch_cnt++;
      end else begin
        want = bytes_due.pop_front();
        if (want.data !== out_data_byte) begin
          $display("%0t ns: data_byte mismatch, expected %0h actual %0h",
                   $time, want.data, out_data_byte);
          mismatch_cnt++;
        end
        if (want.is_first !== out_first_of_packet) begin
          $display("%0t ns: first_of_packet mismatch, expected %0h actual %0h",
                   $time, want.is_first, out_first_of_packet);
          mismatch_cnt++;
        end
        if (want.is_last !== out_last_of_packet) begin
          $display("%0t ns: last_of_packet mismatch, expected %0h actual %0h",
                   $time, want.is_last, out_last_of_packet);
          mismatch_cnt++;
        end
        if (want.offs !== out_packet_offset) begin
          $display("%0t ns: packet_offset mismatch, expected %0h actual %0h",
                   $time, want.offs, out_packet_offset);
          mismatch_cnt++;
        end
      end
    end
  end

  // result side: back-pressure, with one long hold on request
  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 150;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    shadow_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_fill_extremes();
    test_lock_default_sync();
    test_lock_loss();
    test_sync_extremes();
    test_steady_final();
    drain_idle();
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
